/* design/tspm_pkg.sv */
// Shared constants, types and the trigger-port decode for the sample playback mixer.
// Depends on nothing; every other design file except tspm_ram imports this package.
package tspm_pkg;

    localparam int CHANNELS     = 9;
    localparam int SAMPLE_DEPTH = 4096;

    // Fixed field widths of the input and result channels.
    localparam int OP_W         = 3;
    localparam int PORT_W       = 8;
    localparam int CHAN_FIELD_W = 4;
    localparam int ADDR_FIELD_W = 12;
    localparam int BYTE_W       = 8;
    localparam int LEN_FIELD_W  = 13;
    localparam int MIX_W        = 15;

    localparam int CIDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W       = $clog2(SAMPLE_DEPTH + 1);
    localparam int STORE_DEPTH = CHANNELS * SAMPLE_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int SAMPLE_GAIN = 64;
    localparam int GAIN_SHIFT  = $clog2(SAMPLE_GAIN);
    localparam int MIX_MAX     = 32767;
    localparam int SUM_W       = $clog2(CHANNELS * ((1 << BYTE_W) - 1) * SAMPLE_GAIN + 1);

    // Channel driven by each bit of the two trigger ports; NO_CHANNEL bits are ignored.
    localparam logic [7:0] NO_CHANNEL = 8'd255;
    localparam logic [7:0] PORT0_MAP [PORT_W] = '{
        8'd8, 8'd0, NO_CHANNEL, 8'd2, NO_CHANNEL, NO_CHANNEL, NO_CHANNEL, NO_CHANNEL
    };
    localparam logic [7:0] PORT1_MAP [PORT_W] = '{
        8'd3, 8'd4, 8'd5, 8'd6, 8'd1, NO_CHANNEL, NO_CHANNEL, NO_CHANNEL
    };

    typedef enum logic [OP_W-1:0] {
        OP_PORT0  = 3'd0,
        OP_PORT1  = 3'd1,
        OP_TICK   = 3'd2,
        OP_LOAD   = 3'd3,
        OP_SETLEN = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] pos;
    } chan_ent_t;

    typedef struct packed {
        logic              en;
        logic [CIDX_W-1:0] addr;
        chan_ent_t         data;
    } chan_wr_t;

    typedef struct packed {
        logic             valid;
        logic [MIX_W-1:0] sample;
        logic             clipped;
    } mix_result_t;

    typedef struct packed {
        logic [CHANNELS-1:0] set;
        logic [CHANNELS-1:0] clr;
    } port_mask_t;

    // Decodes one trigger port byte into per-channel start and stop masks.
    function automatic port_mask_t port_masks(input logic use_port1,
                                              input logic [PORT_W-1:0] value);
        port_mask_t m;
        logic [7:0] tgt;
        m = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            for (int b = 0; b < PORT_W; b++) begin
                tgt = use_port1 ? PORT1_MAP[b] : PORT0_MAP[b];
                if (tgt == 8'(c)) begin
                    if (value[b]) begin
                        m.set[c] = 1'b1;
                    end else begin
                        m.clr[c] = 1'b1;
                    end
                end
            end
        end
        return m;
    endfunction

endpackage

/* design/tspm_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the sample bytes; no dependencies.
module tspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/tspm_chan_mem.sv */
// Per-channel state memory (length and play position) with a registered read port.
// Entries never written read as zero through a valid bit per entry. Uses tspm_pkg.
module tspm_chan_mem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [tspm_pkg::CIDX_W-1:0] rd_addr,
    output tspm_pkg::chan_ent_t        rd_data,
    input  tspm_pkg::chan_wr_t         wr
);
    import tspm_pkg::*;

    chan_ent_t           ent_mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    chan_ent_t           rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            ent_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ent_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* design/tspm_seq.sv */
// Operation sequencer and mixer: walks the channel state memory one channel per cycle,
// fetches active samples from the sample RAM and accumulates the mix. Uses tspm_pkg.
module tspm_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tspm_pkg::OP_W-1:0]         s_opcode,
    input  logic [tspm_pkg::PORT_W-1:0]       s_port_value,
    input  logic [tspm_pkg::CHAN_FIELD_W-1:0] s_channel,
    input  logic [tspm_pkg::ADDR_FIELD_W-1:0] s_address,
    input  logic [tspm_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic [tspm_pkg::LEN_FIELD_W-1:0]  s_length,
    input  logic                             out_free,
    output tspm_pkg::mix_result_t            result,
    output logic                             chan_rd_en,
    output logic [tspm_pkg::CIDX_W-1:0]       chan_rd_addr,
    input  tspm_pkg::chan_ent_t              chan_rd_data,
    output tspm_pkg::chan_wr_t               chan_wr,
    output logic                             smp_we,
    output logic [tspm_pkg::STORE_AW-1:0]     smp_waddr,
    output logic [tspm_pkg::BYTE_W-1:0]       smp_wdata,
    output logic                             smp_re,
    output logic [tspm_pkg::STORE_AW-1:0]     smp_raddr,
    input  logic [tspm_pkg::BYTE_W-1:0]       smp_rdata
);
    import tspm_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [CIDX_W-1:0]   cnt_reg, cnt_next;
    logic                tick_reg, tick_next;
    logic [CHANNELS-1:0] clr_reg, clr_next;
    logic [CHANNELS-1:0] flags_reg, flags_next;
    logic                s1_vld_reg, s1_vld_next;
    logic [CIDX_W-1:0]   s1_ch_reg, s1_ch_next;
    logic                s2_vld_reg, s2_vld_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;

    op_t        op;
    logic       in_xfer;
    logic       ch_ok;
    logic       addr_ok;
    logic       is_port;
    logic       active;
    logic       clip;
    port_mask_t masks;
    chan_ent_t  ent;
    logic [POS_W-1:0] len_sat;

    assign op      = op_t'(s_opcode);
    assign in_xfer = s_valid && s_ready;
    assign ch_ok   = int'(s_channel) < CHANNELS;
    assign addr_ok = int'(s_address) < SAMPLE_DEPTH;
    assign is_port = (op == OP_PORT0) || (op == OP_PORT1);
    assign masks   = port_masks(op == OP_PORT1, s_port_value);
    assign ent     = chan_rd_data;
    assign len_sat = (int'(s_length) > SAMPLE_DEPTH) ? POS_W'(SAMPLE_DEPTH)
                                                      : POS_W'(s_length);

    // A channel plays only while it is triggered and has samples left.
    assign active = s1_vld_reg && tick_reg && flags_reg[s1_ch_reg] && (ent.pos < ent.len);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (is_port || op == OP_TICK)) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (cnt_reg == CIDX_W'(CHANNELS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!s1_vld_reg && !s2_vld_reg) begin
                    state_next = tick_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign clip = sum_reg > SUM_W'(MIX_MAX);

    // State machine outputs.
    always_comb begin
        s_ready        = 1'b0;
        chan_rd_en     = 1'b0;
        result.valid   = 1'b0;
        result.sample  = clip ? MIX_W'(MIX_MAX) : sum_reg[MIX_W-1:0];
        result.clipped = clip;
        case (state_reg)
            ST_IDLE:   s_ready      = 1'b1;
            ST_SWEEP:  chan_rd_en   = 1'b1;
            ST_DRAIN:  s_ready      = 1'b0;
            ST_RESULT: result.valid = 1'b1;
            default:   s_ready      = 1'b0;
        endcase
    end

    assign chan_rd_addr = cnt_reg;

    // Sample RAM ports: loads write at acceptance, the sweep reads active channels.
    assign smp_we    = in_xfer && (op == OP_LOAD) && ch_ok && addr_ok;
    assign smp_waddr = STORE_AW'(s_channel) * STORE_AW'(SAMPLE_DEPTH) + STORE_AW'(s_address);
    assign smp_wdata = s_data_byte;
    assign smp_re    = active;
    assign smp_raddr = STORE_AW'(s1_ch_reg) * STORE_AW'(SAMPLE_DEPTH) + STORE_AW'(ent.pos);

    always_comb begin
        cnt_next    = cnt_reg;
        tick_next   = tick_reg;
        clr_next    = clr_reg;
        flags_next  = flags_reg;
        sum_next    = sum_reg;
        s1_vld_next = (state_reg == ST_SWEEP);
        s1_ch_next  = cnt_reg;
        s2_vld_next = active;
        chan_wr     = '0;

        if (in_xfer) begin
            tick_next = (op == OP_TICK);
            cnt_next  = '0;
            sum_next  = '0;
            clr_next  = '0;
            if (is_port) begin
                flags_next = (flags_reg | masks.set) & ~masks.clr;
                clr_next   = masks.clr;
            end
        end

        if (state_reg == ST_SWEEP) begin
            cnt_next = cnt_reg + CIDX_W'(1);
        end

        if (s2_vld_reg) begin
            sum_next = sum_reg + (SUM_W'(smp_rdata) << GAIN_SHIFT);
        end

        // Only one writer at a time: set length is taken in idle, the rest during the sweep and drain.
        if (in_xfer && (op == OP_SETLEN) && ch_ok) begin
            chan_wr.en       = 1'b1;
            chan_wr.addr     = CIDX_W'(s_channel);
            chan_wr.data.len = len_sat;
            chan_wr.data.pos = len_sat;
        end else if (active) begin
            chan_wr.en       = 1'b1;
            chan_wr.addr     = s1_ch_reg;
            chan_wr.data.len = ent.len;
            chan_wr.data.pos = ent.pos + POS_W'(1);
        end else if (s1_vld_reg && !tick_reg && clr_reg[s1_ch_reg]) begin
            chan_wr.en       = 1'b1;
            chan_wr.addr     = s1_ch_reg;
            chan_wr.data.len = ent.len;
            chan_wr.data.pos = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            flags_reg  <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            tick_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            flags_reg  <= flags_next;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            tick_reg   <= tick_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        clr_reg   <= clr_next;
        s1_ch_reg <= s1_ch_next;
        sum_reg   <= sum_next;
    end

    // A sample accumulation is always preceded, in the cycle before, by valid channel state read data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("sample accumulate without a preceding channel read");

    // The write-back never hits the entry being read in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && chan_wr.en) |-> (chan_wr.addr != cnt_reg))
        else $error("channel write-back collides with channel read");

    // The result is only offered once the sweep pipeline has drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("result offered with the sweep still in flight");

    // A channel's position never runs past its length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg |-> (ent.pos <= ent.len))
        else $error("channel position beyond its length");

endmodule

/* design/triggered_sample_playback_mixer.sv */
// Nine one-shot sample channels started and stopped by two trigger port bytes and mixed
// into one saturated 15-bit sample per tick. Load, set-length and unused opcodes leave the
// sequencer idle and ready for the next item. A tick or a port write walks the channel
// state memory one channel per cycle and then drains the read pipeline (channel state
// read, then sample RAM read) before the next item is accepted. The tick's result lands
// in the output register, where it may wait while the next item is accepted; a tick that
// finishes while that register is still full holds the input off until the register is
// taken. There is no clearing pass after reset: sample bytes are undefined until loaded.
// Uses tspm_pkg, tspm_seq, tspm_chan_mem and tspm_ram.
module triggered_sample_playback_mixer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tspm_pkg::OP_W-1:0]         s_opcode,
    input  logic [tspm_pkg::PORT_W-1:0]       s_port_value,
    input  logic [tspm_pkg::CHAN_FIELD_W-1:0] s_channel,
    input  logic [tspm_pkg::ADDR_FIELD_W-1:0] s_address,
    input  logic [tspm_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic [tspm_pkg::LEN_FIELD_W-1:0]  s_length,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tspm_pkg::MIX_W-1:0]        m_mixed_sample,
    output logic                             m_clipped
);
    import tspm_pkg::*;

    mix_result_t         result;
    logic                out_free;
    logic                chan_rd_en;
    logic [CIDX_W-1:0]   chan_rd_addr;
    chan_ent_t           chan_rd_data;
    chan_wr_t            chan_wr;
    logic                smp_we;
    logic [STORE_AW-1:0] smp_waddr;
    logic [BYTE_W-1:0]   smp_wdata;
    logic                smp_re;
    logic [STORE_AW-1:0] smp_raddr;
    logic [BYTE_W-1:0]   smp_rdata;

    logic             m_valid_reg, m_valid_next;
    logic [MIX_W-1:0] m_sample_reg, m_sample_next;
    logic             m_clipped_reg, m_clipped_next;

    tspm_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_port_value (s_port_value),
        .s_channel    (s_channel),
        .s_address    (s_address),
        .s_data_byte  (s_data_byte),
        .s_length     (s_length),
        .out_free     (out_free),
        .result       (result),
        .chan_rd_en   (chan_rd_en),
        .chan_rd_addr (chan_rd_addr),
        .chan_rd_data (chan_rd_data),
        .chan_wr      (chan_wr),
        .smp_we       (smp_we),
        .smp_waddr    (smp_waddr),
        .smp_wdata    (smp_wdata),
        .smp_re       (smp_re),
        .smp_raddr    (smp_raddr),
        .smp_rdata    (smp_rdata)
    );

    tspm_chan_mem u_chan_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (chan_rd_en),
        .rd_addr (chan_rd_addr),
        .rd_data (chan_rd_data),
        .wr      (chan_wr)
    );

    tspm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH),
        .AW    (STORE_AW)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (smp_wdata),
        .re    (smp_re),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    // The output register frees up in the same cycle its transfer completes.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_sample_next  = m_sample_reg;
        m_clipped_next = m_clipped_reg;
        if (result.valid && out_free) begin
            m_valid_next   = 1'b1;
            m_sample_next  = result.sample;
            m_clipped_next = result.clipped;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sample_reg  <= m_sample_next;
        m_clipped_reg <= m_clipped_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_mixed_sample = m_sample_reg;
    assign m_clipped      = m_clipped_reg;

endmodule

/* test/tb_triggered_sample_playback_mixer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the triggered sample playback mixer: it drives port writes,
// sample loads, length writes and ticks, and compares every mixed sample with its own model.
// Depends on tspm_pkg and the triggered_sample_playback_mixer RTL.
module tb_triggered_sample_playback_mixer;
    import tspm_pkg::*;

    localparam int unsigned MIX_GAIN    = 64;
    localparam int unsigned MIX_CEILING = 32767;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1700;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int CH_SHOOT     = 0;
    localparam int CH_EXPLOSION = 1;
    localparam int CH_KILLED    = 2;
    localparam int CH_STEP1     = 3;
    localparam int CH_UFO_HIGH  = 7;
    localparam int CH_UFO_LOW   = 8;
    localparam int NO_TRIGGER   = -1;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [PORT_W-1:0]       pv;
        logic [CHAN_FIELD_W-1:0] ch;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [BYTE_W-1:0]       data;
        logic [LEN_FIELD_W-1:0]  len;
    } mixer_cmd_t;

    typedef struct packed {
        logic [MIX_W-1:0] sample;
        logic             clip;
    } mix_expect_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0]         s_opcode     = '0;
    logic [PORT_W-1:0]       s_port_value = '0;
    logic [CHAN_FIELD_W-1:0] s_channel    = '0;
    logic [ADDR_FIELD_W-1:0] s_address    = '0;
    logic [BYTE_W-1:0]       s_data_byte  = '0;
    logic [LEN_FIELD_W-1:0]  s_length     = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [MIX_W-1:0] m_mixed_sample;
    logic m_clipped;

    // Stimulus bookkeeping: which sample bytes have been loaded, so that the random items never
    // give a channel a length that reaches past its contiguous loaded prefix.
    mixer_cmd_t  pending_cmds[$];
    mixer_cmd_t  cur_cmd;
    bit          loaded [CHANNELS][SAMPLE_DEPTH];
    int          loaded_prefix [CHANNELS];
    int unsigned cmds_total;
    int unsigned cmds_accepted;

    // Mixer model state.
    logic [7:0]          model_store [CHANNELS*SAMPLE_DEPTH];
    int unsigned         model_len [CHANNELS];
    int unsigned         model_pos [CHANNELS];
    logic [CHANNELS-1:0] model_playing = '0;
    mix_expect_t         mix_expected[$];
    mix_expect_t         want;

    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned cycle_count;
    int unsigned src_wait;
    int unsigned sink_wait;
    bit          src_calm;
    bit          sink_calm;

    triggered_sample_playback_mixer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_port_value   (s_port_value),
        .s_channel      (s_channel),
        .s_address      (s_address),
        .s_data_byte    (s_data_byte),
        .s_length       (s_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mixed_sample (m_mixed_sample),
        .m_clipped      (m_clipped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Channel started or stopped by one trigger bit; the UFO high channel has no bit.
    function automatic int trigger_channel(input bit port1, input int b);
        if (port1) begin
            if (b <= 3) return CH_STEP1 + b;
            if (b == 4) return CH_EXPLOSION;
            return NO_TRIGGER;
        end
        case (b)
            0: return CH_UFO_LOW;
            1: return CH_SHOOT;
            3: return CH_KILLED;
            default: return NO_TRIGGER;
        endcase
    endfunction

    task automatic apply_transfer(input mixer_cmd_t c);
        int          ch;
        logic [31:0] sum;
        logic        clip;
        int unsigned l;
        case (c.op)
            OP_PORT0, OP_PORT1: begin
                for (int b = 0; b < PORT_W; b++) begin
                    ch = trigger_channel(c.op == OP_PORT1, b);
                    if (ch == NO_TRIGGER || ch >= CHANNELS) continue;
                    if (c.pv[b]) begin
                        model_playing[ch] = 1'b1;
                    end else begin
                        model_playing[ch] = 1'b0;
                        model_pos[ch] = 0;
                    end
                end
            end
            OP_TICK: begin
                sum = 0;
                for (int k = 0; k < CHANNELS; k++) begin
                    if (!model_playing[k]) continue;
                    if (model_pos[k] >= model_len[k] || model_pos[k] >= SAMPLE_DEPTH) continue;
                    sum = sum + model_store[k*SAMPLE_DEPTH + model_pos[k]] * MIX_GAIN;
                    model_pos[k] = model_pos[k] + 1;
                end
                clip = (sum > MIX_CEILING);
                if (clip) sum = MIX_CEILING;
                mix_expected.push_back(mix_expect_t'{sample: sum[MIX_W-1:0], clip: clip});
            end
            OP_LOAD: begin
                if (c.ch < CHANNELS && c.addr < SAMPLE_DEPTH)
                    model_store[c.ch*SAMPLE_DEPTH + c.addr] = c.data;
            end
            OP_SETLEN: begin
                if (c.ch < CHANNELS) begin
                    l = (c.len > SAMPLE_DEPTH) ? SAMPLE_DEPTH : c.len;
                    model_len[c.ch] = l;
                    model_pos[c.ch] = l;
                end
            end
            default: ;
        endcase
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] sample_byte();
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(200, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    // Fields that the operation does not use still carry random values.
    function automatic mixer_cmd_t random_cmd(input logic [OP_W-1:0] op);
        mixer_cmd_t c;
        c.op   = op;
        c.pv   = PORT_W'($urandom);
        c.ch   = CHAN_FIELD_W'($urandom);
        c.addr = ADDR_FIELD_W'($urandom);
        c.data = BYTE_W'($urandom);
        c.len  = LEN_FIELD_W'($urandom);
        return c;
    endfunction

    task automatic queue_load(input int ch, input int addr, input logic [7:0] data);
        mixer_cmd_t c;
        c = random_cmd(OP_LOAD);
        c.ch   = CHAN_FIELD_W'(ch);
        c.addr = ADDR_FIELD_W'(addr);
        c.data = data;
        pending_cmds.push_back(c);
        if (ch < CHANNELS) begin
            loaded[ch][addr] = 1'b1;
            while (loaded_prefix[ch] < SAMPLE_DEPTH && loaded[ch][loaded_prefix[ch]])
                loaded_prefix[ch]++;
        end
    endtask

    task automatic queue_setlen(input int ch, input int len);
        mixer_cmd_t c;
        c = random_cmd(OP_SETLEN);
        c.ch  = CHAN_FIELD_W'(ch);
        c.len = LEN_FIELD_W'(len);
        pending_cmds.push_back(c);
    endtask

    task automatic queue_port(input bit port1, input logic [7:0] value);
        mixer_cmd_t c;
        c = random_cmd(port1 ? OP_PORT1 : OP_PORT0);
        c.pv = value;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            pending_cmds.push_back(random_cmd(OP_TICK));
            // Now and then the trigger ports change in the middle of playback.
            if ($urandom_range(0, 29) == 0) queue_port($urandom_range(0, 1), 8'($urandom));
        end
    endtask

    initial begin
        int         ch;
        int         len;
        int         pick;
        int         port_sel;
        int         bit_sel;
        logic [7:0] value;

        // Directed opening: silent tick after reset, ignored channels, a mix that clips,
        // a channel that runs out, the UFO high channel that never plays, spare opcodes
        // and a length beyond the sample depth.
        queue_ticks(1);
        queue_setlen(15, 8191);
        queue_load(12, 4095, 8'hFF);
        queue_load(CH_SHOOT, 0, 8'hFF);
        queue_load(CH_SHOOT, 1, 8'h00);
        queue_load(CH_KILLED, 0, 8'hFF);
        queue_load(CH_UFO_LOW, 0, 8'hFF);
        queue_load(CH_UFO_HIGH, 0, 8'd200);
        queue_load(CH_STEP1, 0, 8'd1);
        queue_setlen(CH_SHOOT, 2);
        queue_setlen(CH_KILLED, 1);
        queue_setlen(CH_UFO_LOW, 1);
        queue_setlen(CH_UFO_HIGH, 1);
        queue_setlen(CH_STEP1, 1);
        queue_port(1'b0, 8'h00);
        queue_port(1'b0, 8'hFF);
        queue_port(1'b1, 8'h00);
        queue_port(1'b1, 8'h01);
        pending_cmds.push_back(random_cmd(OP_TICK));
        pending_cmds.push_back(random_cmd(OP_TICK));
        pending_cmds.push_back(random_cmd(OP_TICK));
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            pending_cmds.push_back(random_cmd(OP_W'(op)));
        // The explosion channel has nothing loaded, so its length goes straight back to zero.
        queue_setlen(CH_EXPLOSION, 8191);
        queue_setlen(CH_EXPLOSION, 0);

        while (pending_cmds.size() < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // Load a sample, set its length, maybe rewind and start it, then play.
                ch  = $urandom_range(0, CHANNELS - 1);
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(25, 96)
                                                   : $urandom_range(1, 24);
                for (int a = 0; a < len; a++)
                    if (!loaded[ch][a] || $urandom_range(0, 9) == 0)
                        queue_load(ch, a, sample_byte());
                queue_setlen(ch, len);
                bit_sel = -1;
                port_sel = 0;
                for (int p = 0; p < 2; p++)
                    for (int b = 0; b < PORT_W; b++)
                        if (trigger_channel(p, b) == ch) begin
                            port_sel = p;
                            bit_sel = b;
                        end
                if (bit_sel >= 0) begin
                    // Without the rewind the channel stays finished after its length write.
                    if ($urandom_range(0, 3) != 0) begin
                        value = 8'($urandom);
                        value[bit_sel] = 1'b0;
                        queue_port(port_sel, value);
                    end
                    value = 8'($urandom);
                    value[bit_sel] = 1'b1;
                    queue_port(port_sel, value);
                end
                queue_ticks($urandom_range(1, len + 3));
            end else if (pick < 70) begin
                queue_ticks($urandom_range(1, 8));
            end else if (pick < 85) begin
                queue_port($urandom_range(0, 1), 8'($urandom));
            end else begin
                case ($urandom_range(0, 4))
                    0: queue_load($urandom_range(CHANNELS, 15), $urandom_range(0, 4095),
                                  8'($urandom));
                    1: queue_setlen($urandom_range(CHANNELS, 15), $urandom_range(0, 8191));
                    2: pending_cmds.push_back(random_cmd(
                           OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))));
                    3: begin
                        ch = $urandom_range(0, CHANNELS - 1);
                        queue_setlen(ch, $urandom_range(0, loaded_prefix[ch]));
                    end
                    default: queue_load($urandom_range(0, CHANNELS - 1),
                                        $urandom_range(0, 4095), sample_byte());
                endcase
            end
        end
        cmds_total = pending_cmds.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmds_accepted < cmds_total || mix_expected.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Sender: feeds the pending items one transfer at a time with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_wait <= 0;
            src_calm <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_transfer(cur_cmd);
                cmds_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_wait != 0 || pending_cmds.size() == 0) begin
                    s_valid <= 1'b0;
                    if (src_wait != 0) src_wait <= src_wait - 1;
                end else begin
                    cur_cmd = pending_cmds.pop_front();
                    s_opcode     <= cur_cmd.op;
                    s_port_value <= cur_cmd.pv;
                    s_channel    <= cur_cmd.ch;
                    s_address    <= cur_cmd.addr;
                    s_data_byte  <= cur_cmd.data;
                    s_length     <= cur_cmd.len;
                    s_valid      <= 1'b1;
                    src_wait     <= src_calm ? 0 : pick_gap();
                    if ($urandom_range(0, 59) == 0) src_calm <= !src_calm;
                end
            end
        end
    end

    // Receiver: checks each result transfer and stalls at random, with two long hold-offs
    // that back the block up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait <= 0;
            sink_calm <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (mix_expected.size() == 0) begin
                    $display("%0t: result with none expected: mixed_sample %0d clipped %0d",
                             $time, m_mixed_sample, m_clipped);
                    mismatch_count++;
                end else begin
                    want = mix_expected.pop_front();
                    if (m_mixed_sample !== want.sample) begin
                        $display("%0t: mixed_sample expected %0d actual %0d",
                                 $time, want.sample, m_mixed_sample);
                        mismatch_count++;
                    end
                    if (m_clipped !== want.clip) begin
                        $display("%0t: clipped expected %0d actual %0d",
                                 $time, want.clip, m_clipped);
                        mismatch_count++;
                    end
                end
                results_seen++;
            end
            if (m_valid && m_ready && (results_seen == 30 || results_seen == 300)) begin
                sink_wait <= 500;
                m_ready <= 1'b0;
            end else if (sink_wait != 0) begin
                sink_wait <= sink_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 3) == 0) sink_wait <= pick_gap();
            end
            if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
